/* sv/mcr_pkg.sv */
// Package for the midpoint circle rasteriser: mode codes, field widths
// and the iteration record passed from the front end to the span emitter.
// No dependencies.
package mcr_pkg;

    // Input field widths
    localparam int CENTER_W = 12;
    localparam int RADIUS_W = 11;
    localparam int MINOR_W  = 12;
    localparam int DEC_W    = 14;
    localparam int OUT_W    = 14;

    // Packed port widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // Depth of the iteration queue
    localparam int QUEUE_DEPTH = 2;

    // Index of the last result in an iteration
    localparam logic [2:0] LAST_FILL    = 3'd3;
    localparam logic [2:0] LAST_OUTLINE = 3'd7;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        MODE_OUTLINE = 2'd0,
        MODE_FILL    = 2'd1,
        MODE_ADVANCE = 2'd2
    } mode_t;

    // One iteration's worth of work for the span emitter
    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [RADIUS_W-1:0] x;
        logic [MINOR_W-1:0]  y;
        logic                fill;
        logic                fin;
    } job_t;

endpackage

/* sv/mcr_front.sv */
// Front end of the midpoint circle rasteriser: takes start and advance
// words, holds the circle state and steps the decision value.
// Depends on mcr_pkg.
module mcr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [1:0]                   in_mode,
    input  logic [mcr_pkg::CENTER_W-1:0] in_center_x,
    input  logic [mcr_pkg::CENTER_W-1:0] in_center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0] in_radius,
    input  logic                         q_full,
    output logic                         in_ready,
    output logic                         push,
    output mcr_pkg::job_t                push_job
);

    localparam int CTR_W = (COORD_BITS < mcr_pkg::CENTER_W) ? COORD_BITS : mcr_pkg::CENTER_W;

    logic [CTR_W-1:0]             ctr_x_reg, ctr_x_next;
    logic [CTR_W-1:0]             ctr_y_reg, ctr_y_next;
    logic [mcr_pkg::RADIUS_W-1:0] x_reg, x_next;
    logic [mcr_pkg::MINOR_W-1:0]  y_reg, y_next;
    logic [mcr_pkg::DEC_W-1:0]    dec_reg, dec_next;
    logic                         fill_reg, fill_next;
    logic                         active_reg, active_next;

    logic                         accept;
    logic [mcr_pkg::MINOR_W-1:0]  x_ext;
    logic [mcr_pkg::MINOR_W-1:0]  y_inc;
    logic [12:0]                  x_dec_s;
    logic                         dec_le_zero;
    logic [mcr_pkg::DEC_W-1:0]    dec_inc;
    logic [mcr_pkg::DEC_W-1:0]    two_x;
    logic                         fin;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Decision step for the current x, y
    assign x_ext       = {1'b0, x_reg};
    assign y_inc       = y_reg + 12'd1;
    assign x_dec_s     = {2'b00, x_reg} - 13'd1;
    assign dec_le_zero = dec_reg[mcr_pkg::DEC_W-1] || (dec_reg == '0);
    assign dec_inc     = dec_reg + {1'b0, y_inc, 1'b0} + 14'd1;
    assign two_x       = {x_dec_s, 1'b0};
    assign fin         = dec_le_zero ? (x_ext < y_inc)
                                     : ((x_reg == '0) || ((x_ext - 12'd1) < y_inc));

    // Iteration record
    always_comb
    begin
        push_job.cx   = mcr_pkg::CENTER_W'(ctr_x_reg);
        push_job.cy   = mcr_pkg::CENTER_W'(ctr_y_reg);
        push_job.x    = x_reg;
        push_job.y    = y_reg;
        push_job.fill = fill_reg;
        push_job.fin  = fin;
    end

    // State update per accepted word
    always_comb
    begin
        ctr_x_next  = ctr_x_reg;
        ctr_y_next  = ctr_y_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        dec_next    = dec_reg;
        fill_next   = fill_reg;
        active_next = active_reg;
        push        = 1'b0;
        if (accept)
        begin
            unique case (in_mode)
                mcr_pkg::MODE_OUTLINE, mcr_pkg::MODE_FILL:
                begin
                    ctr_x_next  = CTR_W'(in_center_x);
                    ctr_y_next  = CTR_W'(in_center_y);
                    x_next      = in_radius;
                    y_next      = '0;
                    dec_next    = 14'd1 - {3'b000, in_radius};
                    fill_next   = (in_mode == mcr_pkg::MODE_FILL);
                    active_next = 1'b1;
                end
                mcr_pkg::MODE_ADVANCE:
                begin
                    if (active_reg)
                    begin
                        if (x_ext < y_reg)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            push   = 1'b1;
                            y_next = y_inc;
                            if (dec_le_zero)
                            begin
                                dec_next = dec_inc;
                            end
                            else
                            begin
                                x_next   = x_dec_s[mcr_pkg::RADIUS_W-1:0];
                                dec_next = dec_inc - two_x;
                            end
                            if (fin)
                            begin
                                active_next = 1'b0;
                            end
                        end
                    end
                end
                default:
                begin
                    // reserved kind: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_x_reg  <= '0;
            ctr_y_reg  <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            dec_reg    <= '0;
            fill_reg   <= 1'b0;
            active_reg <= 1'b0;
        end
        else
        begin
            ctr_x_reg  <= ctr_x_next;
            ctr_y_reg  <= ctr_y_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            dec_reg    <= dec_next;
            fill_reg   <= fill_next;
            active_reg <= active_next;
        end
    end

    // An iteration is only queued while a circle is running
    a_push_active: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> active_reg && !q_full)
        else $error("iteration queued while idle or queue full");

endmodule

/* sv/mcr_queue.sv */
// Short queue of iteration records between front end and span emitter.
// Depends on mcr_pkg.
module mcr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mcr_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          q_valid,
    output mcr_pkg::job_t head_job
);

    localparam int PTR_W = $clog2(mcr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mcr_pkg::QUEUE_DEPTH + 1);

    mcr_pkg::job_t    mem [mcr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(mcr_pkg::QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_job = mem[rd_ptr_reg];

    // Pointer and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(mcr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> !pop)
        else $error("queue read while empty");

endmodule

/* sv/mcr_back.sv */
// Span emitter: expands one iteration record into four spans or eight
// points, one result word per cycle into an output register unless out_ready holds it.
// Depends on mcr_pkg.
module mcr_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  mcr_pkg::job_t                  head_job,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mcr_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_last,
    output logic                           out_done
);

    mcr_pkg::job_t             job_reg, job_next;
    logic                      busy_reg, busy_next;
    logic [2:0]                k_reg, k_next;
    logic                      ov_reg, ov_next;
    logic [mcr_pkg::OUT_W-1:0] left_reg, left_next;
    logic [mcr_pkg::OUT_W-1:0] right_reg, right_next;
    logic [mcr_pkg::OUT_W-1:0] row_reg, row_next;
    logic                      last_reg, last_next;
    logic                      done_reg, done_next;

    logic                      emit;
    logic                      k_last;
    logic [mcr_pkg::OUT_W-1:0] cx, cy, a, b;
    logic [mcr_pkg::OUT_W-1:0] col_p, col_m, row_p, row_m;

    assign emit   = busy_reg && (!ov_reg || out_ready);
    assign k_last = (k_reg == (job_reg.fill ? mcr_pkg::LAST_FILL : mcr_pkg::LAST_OUTLINE));
    assign pop    = q_valid && (!busy_reg || (emit && k_last));

    // Offsets: outline swaps on bit 2, fill on bit 1
    always_comb
    begin
        cx = mcr_pkg::OUT_W'(job_reg.cx);
        cy = mcr_pkg::OUT_W'(job_reg.cy);
        if (job_reg.fill ? k_reg[1] : k_reg[2])
        begin
            a = mcr_pkg::OUT_W'(job_reg.y);
            b = mcr_pkg::OUT_W'(job_reg.x);
        end
        else
        begin
            a = mcr_pkg::OUT_W'(job_reg.x);
            b = mcr_pkg::OUT_W'(job_reg.y);
        end
        col_p = cx + a;
        col_m = cx - a;
        row_p = cy + b;
        row_m = cy - b;
    end

    // Sequencing and output register
    always_comb
    begin
        job_next   = job_reg;
        busy_next  = busy_reg;
        k_next     = k_reg;
        ov_next    = ov_reg;
        left_next  = left_reg;
        right_next = right_reg;
        row_next   = row_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (emit)
        begin
            ov_next   = 1'b1;
            last_next = k_last;
            done_next = k_last && job_reg.fin;
            if (job_reg.fill)
            begin
                left_next  = col_m;
                right_next = col_p;
                row_next   = k_reg[0] ? row_m : row_p;
            end
            else
            begin
                left_next  = k_reg[0] ? col_m : col_p;
                right_next = k_reg[0] ? col_m : col_p;
                row_next   = k_reg[1] ? row_m : row_p;
            end
            k_next = k_last ? 3'd0 : k_reg + 3'd1;
            if (k_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (pop)
        begin
            job_next  = head_job;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        row_reg   <= row_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= '0;
            ov_reg   <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            k_reg    <= k_next;
            ov_reg   <= ov_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = {6'b000000, row_reg, right_reg, left_reg};
    assign out_last  = last_reg;
    assign out_done  = done_reg;

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && job_reg.fill |-> !k_reg[2])
        else $error("fill iteration ran past four spans");

    a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (k_reg == '0))
        else $error("result counter not cleared between iterations");

    a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && done_reg |-> last_reg)
        else $error("done flagged on a result that is not last");

endmodule

/* sv/midpoint_circle_rasterizer_unit.sv */
// Top level of the midpoint circle rasteriser: front end, iteration queue
// and span emitter. Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back.
//
//  channel | dir | data                                  | side band
//  --------+-----+---------------------------------------+------------------------------
//  s_      | in  | center_x, center_y, radius            | tuser: mode
//  m_      | out | span_left, span_right, span_row       | tlast: last, tuser: done_res
//
// A start word yields nothing. An advance word passes through the front end and
// then yields 4 spans (fill) or 8 points (outline) in the span emitter, which
// writes one result word per cycle into the output register unless m_tready holds it.
// A two-entry iteration queue parts the two halves; s_tready drops only when
// it is full. Reset clears all control state at once; no clearing pass.
module midpoint_circle_rasterizer_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [11:0] center_x, [23:12] center_y, [34:24] radius, [39:35] zero
    input  logic [mcr_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [13:0] span_left, [27:14] span_right, [41:28] span_row, [47:42] zero
    output logic [mcr_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    // [0] done_res
    output logic [0:0]                     m_tuser
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    mcr_pkg::job_t push_job;
    mcr_pkg::job_t head_job;
    logic          done;

    mcr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_mode     (s_tuser),
        .in_center_x (s_tdata[11:0]),
        .in_center_y (s_tdata[23:12]),
        .in_radius   (s_tdata[34:24]),
        .q_full      (q_full),
        .in_ready    (s_tready),
        .push        (push),
        .push_job    (push_job)
    );

    mcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .head_job (head_job)
    );

    mcr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast),
        .out_done  (done)
    );

    assign m_tuser = done;

endmodule

/* dv/midpoint_circle_rasterizer_unit_tb.sv */
// Self-checking testbench for midpoint_circle_rasterizer_unit: drives start and advance
// words, predicts every point or span in-line and checks the output stream in order.
// Depends on mcr_pkg and the rasteriser RTL.
`timescale 1ns / 100ps

module midpoint_circle_rasterizer_unit_tb;

    // Code for the unused input kind
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_WORDS  = 100;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [mcr_pkg::CENTER_W-1:0] cx;
        logic [mcr_pkg::CENTER_W-1:0] cy;
        logic [mcr_pkg::RADIUS_W-1:0] rad;
    } circle_word_t;

    typedef struct packed {
        logic [mcr_pkg::OUT_W-1:0] left;
        logic [mcr_pkg::OUT_W-1:0] right;
        logic [mcr_pkg::OUT_W-1:0] row;
        logic                      last;
        logic                      done;
    } span_t;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mcr_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]                     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mcr_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic [0:0]                     m_tuser;

    circle_word_t pending_words[$];
    span_t        spans_due[$];

    // Idling regime: 0 sender light/receiver heavy, 1 swapped, 2 no idling
    int phase = 0;
    int mismatches = 0;
    int cycles = 0;
    int hold_left = 0;
    bit hold_taken = 1'b0;

    // Shadow circle state
    logic [mcr_pkg::CENTER_W-1:0]   circ_cx;
    logic [mcr_pkg::CENTER_W-1:0]   circ_cy;
    logic [mcr_pkg::RADIUS_W-1:0]   circ_x;
    logic [mcr_pkg::MINOR_W-1:0]    circ_y;
    logic signed [mcr_pkg::DEC_W-1:0] circ_d;
    logic                           circ_fill;
    logic                           circ_busy;

    midpoint_circle_rasterizer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the points or spans one accepted word gives rise to
    task automatic rasterise_word(input logic [1:0] mode,
                                  input logic [mcr_pkg::CENTER_W-1:0] cx_in,
                                  input logic [mcr_pkg::CENTER_W-1:0] cy_in,
                                  input logic [mcr_pkg::RADIUS_W-1:0] rad_in);
        int    cx, cy, x, y, p, n, start_d;
        int    lft[8], rgt[8], rw[8];
        bit    fin;
        span_t s;
        if (mode == mcr_pkg::MODE_OUTLINE || mode == mcr_pkg::MODE_FILL)
        begin
            start_d   = 1 - int'(rad_in);
            circ_cx   = cx_in;
            circ_cy   = cy_in;
            circ_x    = rad_in;
            circ_y    = '0;
            circ_d    = start_d[mcr_pkg::DEC_W-1:0];
            circ_fill = (mode == mcr_pkg::MODE_FILL);
            circ_busy = 1'b1;
            return;
        end
        if (mode != mcr_pkg::MODE_ADVANCE || !circ_busy)
            return;
        cx = circ_cx;
        cy = circ_cy;
        x  = circ_x;
        y  = circ_y;
        p  = circ_d;
        if (x < y)
        begin
            circ_busy = 1'b0;
            return;
        end
        if (circ_fill)
        begin
            lft[0] = cx - x; rgt[0] = cx + x; rw[0] = cy + y;
            lft[1] = cx - x; rgt[1] = cx + x; rw[1] = cy - y;
            lft[2] = cx - y; rgt[2] = cx + y; rw[2] = cy + x;
            lft[3] = cx - y; rgt[3] = cx + y; rw[3] = cy - x;
            n = 4;
        end
        else
        begin
            lft[0] = cx + x; rw[0] = cy + y;
            lft[1] = cx - x; rw[1] = cy + y;
            lft[2] = cx + x; rw[2] = cy - y;
            lft[3] = cx - x; rw[3] = cy - y;
            lft[4] = cx + y; rw[4] = cy + x;
            lft[5] = cx - y; rw[5] = cy + x;
            lft[6] = cx + y; rw[6] = cy - x;
            lft[7] = cx - y; rw[7] = cy - x;
            for (int k = 0; k < 8; k++)
                rgt[k] = lft[k];
            n = 8;
        end
        // decision update, then finish test on the new offsets
        y = y + 1;
        if (p <= 0)
        begin
            p = p + 2 * y + 1;
        end
        else
        begin
            x = x - 1;
            p = p + 2 * y - 2 * x + 1;
        end
        fin    = (x < y);
        circ_x = x[mcr_pkg::RADIUS_W-1:0];
        circ_y = y[mcr_pkg::MINOR_W-1:0];
        circ_d = p[mcr_pkg::DEC_W-1:0];
        if (fin)
            circ_busy = 1'b0;
        for (int k = 0; k < n; k++)
        begin
            s.left  = lft[k][mcr_pkg::OUT_W-1:0];
            s.right = rgt[k][mcr_pkg::OUT_W-1:0];
            s.row   = rw[k][mcr_pkg::OUT_W-1:0];
            s.last  = (k == n - 1);
            s.done  = (k == n - 1) && fin;
            spans_due.push_back(s);
        end
    endtask

    // Sender: holds a word until taken, idles at random between words
    always @(posedge clk or negedge rst_n)
    begin
        int           idle_pct;
        circle_word_t w;
        if (!rst_n)
        begin
            s_tvalid  <= 1'b0;
            s_tdata   <= '0;
            s_tuser   <= '0;
            circ_cx   = '0;
            circ_cy   = '0;
            circ_x    = '0;
            circ_y    = '0;
            circ_d    = '0;
            circ_fill = 1'b0;
            circ_busy = 1'b0;
        end
        else
        begin
            idle_pct = (phase == 0) ? 15 : (phase == 1) ? 82 : 0;
            if (s_tvalid && s_tready)
                rasterise_word(s_tuser, s_tdata[11:0], s_tdata[23:12], s_tdata[34:24]);
            if (!s_tvalid || s_tready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    w = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, w.rad, w.cy, w.cx};
                    s_tuser  <= w.mode;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off at the start of the last regime
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (phase == 2 && !hold_taken)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: checks each taken word against the oldest expected span
    always @(posedge clk or negedge rst_n)
    begin
        int    idle_pct;
        span_t got;
        span_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            idle_pct = (phase == 0) ? 82 : (phase == 1) ? 15 : 0;
            if (m_tvalid && m_tready)
            begin
                got.left  = m_tdata[13:0];
                got.right = m_tdata[27:14];
                got.row   = m_tdata[41:28];
                got.last  = m_tlast;
                got.done  = m_tuser[0];
                if (spans_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0d: unexpected word left=%0d right=%0d row=%0d",
                                 cycles, $signed(got.left), $signed(got.right),
                                 $signed(got.row));
                end
                else
                begin
                    want = spans_due.pop_front();
                    if (got.left != want.left || got.right != want.right ||
                        got.row != want.row || got.last != want.last ||
                        got.done != want.done)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"%0d: span mismatch exp l=%0d r=%0d row=%0d last=%0b ",
                                      "done=%0b got l=%0d r=%0d row=%0d last=%0b done=%0b"},
                                     cycles, $signed(want.left), $signed(want.right),
                                     $signed(want.row), want.last, want.done,
                                     $signed(got.left), $signed(got.right),
                                     $signed(got.row), got.last, got.done);
                    end
                end
            end
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_word(input logic [1:0] mode, input int cx, input int cy, input int rad);
        circle_word_t w;
        w.mode = mode;
        w.cx   = cx[mcr_pkg::CENTER_W-1:0];
        w.cy   = cy[mcr_pkg::CENTER_W-1:0];
        w.rad  = rad[mcr_pkg::RADIUS_W-1:0];
        pending_words.push_back(w);
    endtask

    // One circle: a start word and a run of advances, sometimes cut short,
    // sometimes overrunning into idle advances, with odd reserved words
    task automatic queue_circle(inout int count);
        int sel, rad, full, n_adv;
        sel = $urandom_range(99);
        if (sel < 75)
            rad = $urandom_range(24);
        else if (sel < 93)
            rad = $urandom_range(200, 25);
        else
            rad = $urandom_range(2047, 1900);
        queue_word($urandom_range(1) ? mcr_pkg::MODE_FILL : mcr_pkg::MODE_OUTLINE,
                   $urandom_range(4095), $urandom_range(4095), rad);
        count++;
        full = rad * 3 / 4 + 2;
        if (rad > 24)
            n_adv = $urandom_range(10, 2);
        else if ($urandom_range(9) == 0)
            n_adv = $urandom_range(full);
        else
            n_adv = full;
        for (int k = 0; k < n_adv; k++)
        begin
            if ($urandom_range(14) == 0)
            begin
                queue_word(MODE_RESERVED, $urandom_range(4095), $urandom_range(4095),
                           $urandom_range(2047));
                count++;
            end
            queue_word(mcr_pkg::MODE_ADVANCE, $urandom_range(4095), $urandom_range(4095),
                       $urandom_range(2047));
            count++;
        end
    endtask

    task automatic queue_random_phase();
        int count;
        count = 0;
        while (count < PHASE_WORDS)
            queue_circle(count);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: zero and full radius, extreme centres, idle advance,
        // reserved words, restart while a circle is running
        queue_word(mcr_pkg::MODE_OUTLINE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_ADVANCE, 4095, 4095, 2047);
        queue_word(MODE_RESERVED, 0, 0, 0);
        queue_word(mcr_pkg::MODE_FILL, 4095, 4095, 0);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_OUTLINE, 4095, 0, 2047);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_FILL, 0, 4095, 2047);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(MODE_RESERVED, 4095, 4095, 2047);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_OUTLINE, 'hAAA, 'h555, 3);
        queue_word(mcr_pkg::MODE_ADVANCE, 0, 0, 0);
        queue_word(mcr_pkg::MODE_FILL, 'h555, 'hAAA, 3);
        repeat (4) queue_word(mcr_pkg::MODE_ADVANCE, 4095, 4095, 2047);
        queue_random_phase();
        wait_drained();

        phase = 1;
        queue_random_phase();
        wait_drained();

        // Last regime opens with the long receiver hold-off
        phase = 2;
        queue_random_phase();
        wait_drained();

        while (spans_due.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
